// File: design/assert_macros.svh
// Assertion macros shared by the debounce and press classifier RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BDPC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Same-cycle check failed.");

// Next-cycle implication, sampled on the rising clock edge.
`define BDPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Next-cycle check failed.");

`endif

// File: design/bdpc_pkg.sv
// Package for the button debounce and press classifier.
// Holds field widths, register indexes and reset values; depends on nothing.
package bdpc_pkg;

   localparam int TIME_WIDTH_DEF = 32;
   localparam int STAMP_W        = 32;
   localparam int DELAY_W        = 16;
   localparam int CSR_INDEX_W    = 2;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [DELAY_W-1:0]     delay_type;

   localparam csr_index_type REG_DEBOUNCE   = 2'd0;
   localparam csr_index_type REG_LONG_PRESS = 2'd1;

   localparam delay_type DEBOUNCE_RESET   = 16'd50;
   localparam delay_type LONG_PRESS_RESET = 16'd1000;

endpackage

// File: design/bdpc_req_if.sv
// Poll channel interface: raw button level and millisecond timestamp.
// Depends on bdpc_pkg.
interface bdpc_req_if;
   import bdpc_pkg::*;

   logic               valid;
   logic               ready;
   logic               raw_level;
   logic [STAMP_W-1:0] now_ms;

   modport source (output valid, output raw_level, output now_ms, input ready);
   modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

// File: design/bdpc_rsp_if.sv
// Result channel interface: debounced level and press pulses.
// Depends on nothing beyond the language.
interface bdpc_rsp_if;
   logic valid;
   logic ready;
   logic pressed;
   logic short_press;
   logic long_press;

   modport source (output valid, output pressed, output short_press, output long_press,
                   input ready);
   modport sink   (input valid, input pressed, input short_press, input long_press,
                   output ready);
endinterface

// File: design/bdpc_csr_if.sv
// Register write channel interface: register index and write data.
// Depends on bdpc_pkg.
interface bdpc_csr_if;
   import bdpc_pkg::*;

   logic          valid;
   logic          ready;
   csr_index_type index;
   delay_type     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/button_debounce_press_classifier_top.sv
// Channel     Dir  Beat contents
// req_bus     in   raw_level (active low), now_ms
// rsp_bus     out  pressed, short_press, long_press
// csr_bus     in   index, data (debounce_ms, long_press_ms)
//
// One poll beat is taken every cycle while the result channel does not stall; its result beat
// passes through one input register, the classifier and one result register before it is valid.
// Reset is synchronous and active high; it restores released state and default delays.
// A stalled result holds in the result register, and the input register then fills and
// drops req_bus.ready. Register writes are always taken.
// Depends on bdpc_pkg, the three channel interfaces and assert_macros.svh.
`include "assert_macros.svh"

module button_debounce_press_classifier_top #(
   parameter int TIME_WIDTH = bdpc_pkg::TIME_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   bdpc_req_if.sink   req_bus,
   bdpc_rsp_if.source rsp_bus,
   bdpc_csr_if.sink   csr_bus
);
   import bdpc_pkg::*;

   typedef logic [TIME_WIDTH-1:0] time_type;

   delay_type debounce_ff;
   delay_type long_ms_ff;

   logic     s1_valid_ff;
   logic     s1_raw_ff;
   time_type s1_now_ff;

   logic     prev_raw_ff;
   logic     stable_ff;
   time_type change_time_ff;
   time_type press_start_ff;
   logic     long_fired_ff;

   logic     rsp_valid_ff;
   logic     pressed_ff;
   logic     short_ff;
   logic     long_ff;

   logic     s1_advance;
   time_type change_time_in;
   time_type db_elapsed;
   time_type lp_elapsed;
   logic     db_accept;
   logic     new_press;
   logic     stable_in;
   time_type press_start_in;
   logic     long_fired_in;
   logic     short_in;
   logic     long_in;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         long_ms_ff  <= LONG_PRESS_RESET;
      end else if (csr_bus.valid) begin
         if (csr_bus.index == REG_DEBOUNCE) begin
            debounce_ff <= csr_bus.data;
         end else if (csr_bus.index == REG_LONG_PRESS) begin
            long_ms_ff <= csr_bus.data;
         end
      end
   end

   assign s1_advance    = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_raw_ff <= req_bus.raw_level;
         s1_now_ff <= TIME_WIDTH'(req_bus.now_ms);
      end
   end

   always_comb begin
      change_time_in = (s1_raw_ff != prev_raw_ff) ? s1_now_ff : change_time_ff;
      db_elapsed     = s1_now_ff - change_time_in;
      lp_elapsed     = s1_now_ff - press_start_ff;
      db_accept      = (db_elapsed > TIME_WIDTH'(debounce_ff)) && (s1_raw_ff != stable_ff);
      new_press      = db_accept && !s1_raw_ff;
      stable_in      = db_accept ? s1_raw_ff : stable_ff;
      press_start_in = new_press ? s1_now_ff : press_start_ff;
      short_in       = db_accept && s1_raw_ff && !long_fired_ff;
      long_in        = !stable_in && !long_fired_ff && !new_press &&
                       (lp_elapsed > TIME_WIDTH'(long_ms_ff));
      long_fired_in  = (long_fired_ff && !new_press) || long_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff    <= 1'b1;
         stable_ff      <= 1'b1;
         change_time_ff <= '0;
         press_start_ff <= '0;
         long_fired_ff  <= 1'b0;
      end else if (s1_advance) begin
         prev_raw_ff    <= s1_raw_ff;
         stable_ff      <= stable_in;
         change_time_ff <= change_time_in;
         press_start_ff <= press_start_in;
         long_fired_ff  <= long_fired_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         pressed_ff <= !stable_in;
         short_ff   <= short_in;
         long_ff    <= long_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pressed     = pressed_ff;
   assign rsp_bus.short_press = short_ff;
   assign rsp_bus.long_press  = long_ff;

   `BDPC_ASSERT_SAME(a_pulses_exclusive, clock, reset, rsp_valid_ff, !(short_ff && long_ff))
   `BDPC_ASSERT_SAME(a_long_while_pressed, clock, reset, rsp_valid_ff && long_ff, pressed_ff)
   `BDPC_ASSERT_NEXT(a_long_marks_fired, clock, reset, s1_advance && long_in, long_fired_ff)
   `BDPC_ASSERT_SAME(a_stall_from_input_reg, clock, reset, !req_bus.ready, s1_valid_ff && rsp_valid_ff)

endmodule
